// ===== rtl/sscm_pkg.sv =====
package sscm_pkg;

   // one table entry: physical offset, length, logical base of a piece
   typedef struct packed {
      logic [63:0] offset;
      logic [31:0] length;
      logic [63:0] base;
   } entry_type;

   // storage method accepted by the table builder
   localparam logic [7:0] METHOD_STORED = 8'h30;

   // result status codes
   localparam logic [2:0] ST_APPENDED     = 3'd0;
   localparam logic [2:0] ST_NOT_APPENDED = 3'd1;
   localparam logic [2:0] ST_COMPRESSED   = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
   localparam logic [2:0] ST_TRANSLATED   = 3'd4;
   localparam logic [2:0] ST_TABLE_EMPTY  = 3'd5;

   // command codes
   localparam logic CMD_HEADER    = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

endpackage

// ===== rtl/sscm_ram.sv =====
module sscm_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  sscm_pkg::entry_type  wr_data,
   input  logic [AW-1:0]        rd_addr,
   output sscm_pkg::entry_type  rd_data
);
   import sscm_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/segmented_stream_chunk_map.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | cmd, method, file_size, flags, offset, size, position
// rsp     | out       | rsp_valid/rsp_stall  | status, replaced, translation, total, count
//
// a header transaction's result is registered at acceptance; the piece is written to the table at acceptance
// a translate transaction reads the table memory one entry per cycle from piece 0 until the first
//    piece whose end lies beyond the position, or else the last piece, and then registers the result
// reset is synchronous; it empties the table (count, total, file flags), entries stay unwritten
// a finished result waits in the output register under rsp_stall; a new transaction is taken
//    once the walk is done and the output register is free or being drained
module segmented_stream_chunk_map #(
   parameter int MAX_PIECES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_method,
   input  logic [63:0] req_file_size,
   input  logic        req_has_previous,
   input  logic        req_has_next,
   input  logic [63:0] req_data_offset,
   input  logic [31:0] req_chunk_size,
   input  logic [63:0] req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_replaced,
   output logic [63:0] rsp_physical_offset,
   output logic [5:0]  rsp_piece_index,
   output logic [31:0] rsp_bytes_left,
   output logic [63:0] rsp_clamped_position,
   output logic [63:0] rsp_total_size,
   output logic [6:0]  rsp_piece_count
);
   import sscm_pkg::*;

   localparam int IW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int CW = $clog2(MAX_PIECES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIECES);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_FIN1 = 4'b0100,
      S_FIN2 = 4'b1000
   } state_type;

   // control state
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   total_ff, total_in;
   logic [63:0]   decl_ff, decl_in;
   logic          have_file_ff, have_file_in;
   logic          complete_ff, complete_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // walk payload
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] sel_idx_ff, sel_idx_in;
   logic [63:0]   pos_ff, pos_in;
   entry_type     sel_ff, sel_in;
   logic [63:0]   end_ff, end_in;
   logic [63:0]   diff_ff, diff_in;
   logic [31:0]   left_ff, left_in;

   // result payload
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_replaced_ff, rsp_replaced_in;
   logic [63:0]   rsp_phys_ff, rsp_phys_in;
   logic [IW-1:0] rsp_idx_ff, rsp_idx_in;
   logic [31:0]   rsp_left_ff, rsp_left_in;
   logic [63:0]   rsp_pos_ff, rsp_pos_in;
   logic [63:0]   rsp_total_ff, rsp_total_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   // memory port
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   entry_type     rd_data;

   // header decode
   logic          req_acc;
   logic          out_free;
   logic          hdr_stored, hdr_replace, hdr_new, hdr_take, hdr_full;
   logic [CW-1:0] eff_count;
   logic [63:0]   eff_total, eff_decl;
   logic          eff_complete;
   logic [2:0]    hdr_status;
   logic [IW-1:0] last_idx;
   logic [63:0]   walk_end;
   logic          walk_hit;
   logic [IW+5:0] idx_wide;
   logic [CW+6:0] cnt_wide;

   sscm_ram #(
      .DEPTH (MAX_PIECES),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;

   // header event: new file detection and append decision
   always_comb begin
      hdr_stored   = (req_method == METHOD_STORED);
      hdr_replace  = have_file_ff && (decl_ff < req_file_size);
      hdr_new      = !have_file_ff || hdr_replace;
      eff_count    = hdr_new ? '0 : count_ff;
      eff_total    = hdr_new ? 64'd0 : total_ff;
      eff_decl     = hdr_new ? req_file_size : decl_ff;
      eff_complete = hdr_new ? 1'b0 : complete_ff;
      hdr_take     = !eff_complete && ((eff_count == '0) ||
                     ((eff_decl == req_file_size) && req_has_previous));
      hdr_full     = (eff_count >= MAX_CNT);
      if (!hdr_stored) begin
         hdr_status = ST_COMPRESSED;
      end else if (hdr_take && hdr_full) begin
         hdr_status = ST_TABLE_FULL;
      end else if (hdr_take) begin
         hdr_status = ST_APPENDED;
      end else begin
         hdr_status = ST_NOT_APPENDED;
      end
   end

   assign wr_en   = req_acc && (req_cmd == CMD_HEADER) && hdr_stored && hdr_take && !hdr_full;
   assign wr_addr = eff_count[IW-1:0];
   assign wr_data = '{offset: req_data_offset, length: req_chunk_size, base: eff_total};

   // end of the piece being checked in the walk
   assign last_idx = IW'(count_ff - CW'(1));
   assign walk_end = rd_data.base + {32'd0, rd_data.length};
   assign walk_hit = pos_ff < walk_end;

   // sequencer and next-state logic
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      decl_in         = decl_ff;
      have_file_in    = have_file_ff;
      complete_in     = complete_ff;
      chk_vld_in      = 1'b0;
      rd_idx_in       = rd_idx_ff;
      chk_idx_in      = chk_idx_ff;
      sel_idx_in      = sel_idx_ff;
      pos_in          = pos_ff;
      sel_in          = sel_ff;
      end_in          = end_ff;
      diff_in         = diff_ff;
      left_in         = left_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_replaced_in = rsp_replaced_ff;
      rsp_phys_in     = rsp_phys_ff;
      rsp_idx_in      = rsp_idx_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_pos_in      = rsp_pos_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_count_in    = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_cmd == CMD_HEADER)) begin
               if (hdr_stored) begin
                  have_file_in = 1'b1;
                  decl_in      = eff_decl;
                  complete_in  = eff_complete || !req_has_next;
                  count_in     = eff_count + CW'(wr_en);
                  total_in     = wr_en ? (eff_total + {32'd0, req_chunk_size}) : eff_total;
               end
               rsp_valid_in    = 1'b1;
               rsp_status_in   = hdr_status;
               rsp_replaced_in = hdr_stored && hdr_replace;
               rsp_phys_in     = 64'd0;
               rsp_idx_in      = '0;
               rsp_left_in     = 32'd0;
               rsp_pos_in      = 64'd0;
               rsp_total_in    = hdr_stored ? total_in : total_ff;
               rsp_count_in    = hdr_stored ? count_in : count_ff;
            end else if (req_acc && (count_ff == '0)) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_TABLE_EMPTY;
               rsp_replaced_in = 1'b0;
               rsp_phys_in     = 64'd0;
               rsp_idx_in      = '0;
               rsp_left_in     = 32'd0;
               rsp_pos_in      = 64'd0;
               rsp_total_in    = total_ff;
               rsp_count_in    = count_ff;
            end else if (req_acc) begin
               // clamp the position and start the walk at piece 0
               pos_in    = (req_position > total_ff) ? total_ff : req_position;
               rd_idx_in = '0;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            // issue the next read while checking the previous one
            chk_vld_in = 1'b1;
            chk_idx_in = rd_idx_ff;
            rd_idx_in  = (rd_idx_ff == last_idx) ? rd_idx_ff : rd_idx_ff + IW'(1);
            if (chk_vld_ff && (walk_hit || (chk_idx_ff == last_idx))) begin
               chk_vld_in = 1'b0;
               sel_in     = rd_data;
               sel_idx_in = chk_idx_ff;
               end_in     = walk_end;
               state_in   = S_FIN1;
            end
         end
         S_FIN1: begin
            diff_in  = pos_ff - sel_ff.base;
            left_in  = (end_ff > pos_ff) ? 32'(end_ff - pos_ff) : 32'd0;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_TRANSLATED;
               rsp_replaced_in = 1'b0;
               rsp_phys_in     = sel_ff.offset + diff_ff;
               rsp_idx_in      = sel_idx_ff;
               rsp_left_in     = left_ff;
               rsp_pos_in      = pos_ff;
               rsp_total_in    = total_ff;
               rsp_count_in    = count_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= 64'd0;
         decl_ff      <= 64'd0;
         have_file_ff <= 1'b0;
         complete_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         decl_ff      <= decl_in;
         have_file_ff <= have_file_in;
         complete_ff  <= complete_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      chk_idx_ff      <= chk_idx_in;
      sel_idx_ff      <= sel_idx_in;
      pos_ff          <= pos_in;
      sel_ff          <= sel_in;
      end_ff          <= end_in;
      diff_ff         <= diff_in;
      left_ff         <= left_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_replaced_ff <= rsp_replaced_in;
      rsp_phys_ff     <= rsp_phys_in;
      rsp_idx_ff      <= rsp_idx_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // result ports
   assign idx_wide = {6'd0, rsp_idx_ff};
   assign cnt_wide = {7'd0, rsp_count_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_replaced         = rsp_replaced_ff;
   assign rsp_physical_offset  = rsp_phys_ff;
   assign rsp_piece_index      = idx_wide[5:0];
   assign rsp_bytes_left       = rsp_left_ff;
   assign rsp_clamped_position = rsp_pos_ff;
   assign rsp_total_size       = rsp_total_ff;
   assign rsp_piece_count      = cnt_wide[6:0];

`ifndef SYNTH
   // no new transaction while a walk is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("transaction accepted during a walk");

   // table never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("piece count beyond capacity");

   // a translate on a filled table starts the walk
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_cmd == CMD_TRANSLATE) && (count_ff != '0)) |=> (state_ff == S_WALK))
      else $error("translate did not start the walk");

   // a checked index stays within the filled part of the table
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) && chk_vld_ff) |-> (chk_idx_ff <= last_idx))
      else $error("walk checked an unfilled entry");

   // a table write only happens while idle
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_IDLE))
      else $error("table written outside idle");
`endif

endmodule

// ===== tb/tb_segmented_stream_chunk_map.sv =====
`timescale 1ns / 1ps

module tb_segmented_stream_chunk_map;
   import sscm_pkg::*;

   localparam int MAX_PIECES = 64;
   localparam int IDLE_PCT = 27;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;
   localparam int RANDOM_ITEMS = 1750;

   typedef struct {
      logic        cmd;
      logic [7:0]  method;
      logic [63:0] file_size;
      logic        has_previous;
      logic        has_next;
      logic [63:0] data_offset;
      logic [31:0] chunk_size;
      logic [63:0] position;
   } request_type;

   typedef struct {
      logic [2:0]  status;
      logic        replaced;
      logic [63:0] physical_offset;
      logic [5:0]  piece_index;
      logic [31:0] bytes_left;
      logic [63:0] clamped_position;
      logic [63:0] total_size;
      logic [6:0]  piece_count;
   } result_type;

   // mirror of the piece table plus the queue of results still owed by the block
   class piece_table_tracker_type;
      logic [63:0] offsets [MAX_PIECES];
      logic [31:0] lengths [MAX_PIECES];
      logic [63:0] bases [MAX_PIECES];
      int unsigned npieces;
      logic [63:0] total;
      logic [63:0] declared;
      bit          have_file;
      bit          complete;
      result_type  pending_results [$];
      int unsigned failures;

      function new();
         npieces = 0;
         total = '0;
         declared = '0;
         have_file = 1'b0;
         complete = 1'b0;
         failures = 0;
      endfunction

      // update the mirror with one accepted transaction and queue its result
      function void note_request(request_type r);
         result_type  res;
         logic [63:0] pos;
         logic [63:0] endp;
         int unsigned sel;
         res = '{default: '0};
         if (r.cmd == CMD_HEADER) begin
            if (r.method != METHOD_STORED) begin
               res.status = ST_COMPRESSED;
            end else begin
               // a larger file throws away the current table
               if (have_file && declared < r.file_size) begin
                  have_file = 1'b0;
                  res.replaced = 1'b1;
               end
               if (!have_file) begin
                  have_file = 1'b1;
                  declared = r.file_size;
                  complete = 1'b0;
                  total = '0;
                  npieces = 0;
               end
               res.status = ST_NOT_APPENDED;
               if (!complete) begin
                  if (npieces == 0 || (declared == r.file_size && r.has_previous)) begin
                     if (npieces >= MAX_PIECES) begin
                        res.status = ST_TABLE_FULL;
                     end else begin
                        bases[npieces] = (npieces == 0) ? 64'd0 :
                           bases[npieces-1] + {32'd0, lengths[npieces-1]};
                        offsets[npieces] = r.data_offset;
                        lengths[npieces] = r.chunk_size;
                        npieces++;
                        total += {32'd0, r.chunk_size};
                        res.status = ST_APPENDED;
                     end
                  end
                  if (!r.has_next) complete = 1'b1;
               end
            end
         end else if (npieces == 0) begin
            res.status = ST_TABLE_EMPTY;
         end else begin
            // clamp, then walk to the first piece ending beyond the position
            pos = (r.position > total) ? total : r.position;
            sel = 0;
            endp = '0;
            for (int i = 0; i < npieces; i++) begin
               sel = i;
               endp = bases[i] + {32'd0, lengths[i]};
               if (pos < endp) break;
            end
            res.status = ST_TRANSLATED;
            res.physical_offset = offsets[sel] + (pos - bases[sel]);
            res.piece_index = sel[5:0];
            res.bytes_left = (endp > pos) ? 32'(endp - pos) : 32'd0;
            res.clamped_position = pos;
         end
         res.total_size = total;
         res.piece_count = npieces[6:0];
         pending_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
         if (exp_val !== act_val) begin
            $error("%s expected %0h actual %0h", name, exp_val, act_val);
            failures++;
         end
      endfunction

      // compare one delivered result with the oldest one owed
      function void check_response(result_type act);
         result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction, status %0d", act.status);
            failures++;
            return;
         end
         exp_res = pending_results.pop_front();
         compare_field("status", exp_res.status, act.status);
         compare_field("replaced", exp_res.replaced, act.replaced);
         compare_field("physical_offset", exp_res.physical_offset, act.physical_offset);
         compare_field("piece_index", exp_res.piece_index, act.piece_index);
         compare_field("bytes_left", exp_res.bytes_left, act.bytes_left);
         compare_field("clamped_position", exp_res.clamped_position, act.clamped_position);
         compare_field("total_size", exp_res.total_size, act.total_size);
         compare_field("piece_count", exp_res.piece_count, act.piece_count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [7:0]  req_method;
   logic [63:0] req_file_size;
   logic        req_has_previous;
   logic        req_has_next;
   logic [63:0] req_data_offset;
   logic [31:0] req_chunk_size;
   logic [63:0] req_position;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic        rsp_replaced;
   logic [63:0] rsp_physical_offset;
   logic [5:0]  rsp_piece_index;
   logic [31:0] rsp_bytes_left;
   logic [63:0] rsp_clamped_position;
   logic [63:0] rsp_total_size;
   logic [6:0]  rsp_piece_count;

   piece_table_tracker_type tracker = new();
   bit          no_idle = 1'b0;
   bit          rsp_hold_req = 1'b0;
   int unsigned stim_count = 0;

   segmented_stream_chunk_map #(
      .MAX_PIECES(MAX_PIECES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_method(req_method),
      .req_file_size(req_file_size),
      .req_has_previous(req_has_previous),
      .req_has_next(req_has_next),
      .req_data_offset(req_data_offset),
      .req_chunk_size(req_chunk_size),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_replaced(rsp_replaced),
      .rsp_physical_offset(rsp_physical_offset),
      .rsp_piece_index(rsp_piece_index),
      .rsp_bytes_left(rsp_bytes_left),
      .rsp_clamped_position(rsp_clamped_position),
      .rsp_total_size(rsp_total_size),
      .rsp_piece_count(rsp_piece_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic request_type header_req(logic [7:0] method, logic [63:0] fsize, bit prev,
                                              bit nxt, logic [63:0] offset, logic [31:0] len);
      request_type r;
      r.cmd = CMD_HEADER;
      r.method = method;
      r.file_size = fsize;
      r.has_previous = prev;
      r.has_next = nxt;
      r.data_offset = offset;
      r.chunk_size = len;
      r.position = rand64();
      return r;
   endfunction

   function automatic request_type translate_req(logic [63:0] pos);
      request_type r;
      r.cmd = CMD_TRANSLATE;
      r.method = 8'($urandom);
      r.file_size = rand64();
      r.has_previous = 1'($urandom);
      r.has_next = 1'($urandom);
      r.data_offset = rand64();
      r.chunk_size = $urandom;
      r.position = pos;
      return r;
   endfunction

   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         default: return 32'($urandom_range(1, 5000));
      endcase
   endfunction

   // positions near zero, the end, piece boundaries, beyond the end and anywhere
   function automatic logic [63:0] pick_position();
      logic [63:0] pos;
      int unsigned k;
      pos = '0;
      case ($urandom_range(0, 7))
         0: pos = '0;
         1: pos = tracker.total;
         2: pos = tracker.total + 64'($urandom_range(1, 1000));
         3: pos = rand64();
         4, 5: begin
            if (tracker.npieces > 0) begin
               k = $urandom_range(0, tracker.npieces - 1);
               pos = tracker.bases[k] + 64'($urandom_range(0, 2)) - 64'd1;
            end
         end
         default: pos = (tracker.total == 0) ? 64'd0 : rand64() % tracker.total;
      endcase
      return pos;
   endfunction

   // offer one transaction and hold it until the block takes it
   task automatic send_request(request_type r);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_method <= r.method;
      req_file_size <= r.file_size;
      req_has_previous <= r.has_previous;
      req_has_next <= r.has_next;
      req_data_offset <= r.data_offset;
      req_chunk_size <= r.chunk_size;
      req_position <= r.position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
      if (r.cmd == CMD_TRANSLATE || r.method == METHOD_STORED) stim_count++;
   endtask

   // stop offering and wait for every owed result
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   // broken or stray transactions
   task automatic send_noise();
      logic [7:0]  m;
      logic [63:0] fsize;
      case ($urandom_range(0, 4))
         0: begin
            m = 8'($urandom);
            if (m == METHOD_STORED) m = ~m;
            send_request(header_req(m, rand64(), 1'($urandom), 1'($urandom), rand64(),
                                    $urandom));
         end
         1: begin
            fsize = (tracker.declared > 64'd100) ?
               tracker.declared - 64'($urandom_range(1, 100)) : 64'd0;
            send_request(header_req(METHOD_STORED, fsize, 1'($urandom), 1'($urandom),
                                    rand64(), pick_length()));
         end
         2: begin
            fsize = tracker.declared + 64'($urandom_range(1, 4096));
            send_request(header_req(METHOD_STORED, fsize, 1'($urandom), 1'($urandom),
                                    rand64(), pick_length()));
         end
         3: send_request(header_req(METHOD_STORED, tracker.declared, 1'b0, 1'($urandom),
                                    rand64(), pick_length()));
         default: send_request(translate_req(rand64()));
      endcase
   endtask

   // one file as a well-formed chain of pieces, with lookups and noise mixed in
   task automatic send_file(int unsigned n);
      logic [63:0] fsize;
      fsize = tracker.declared + 64'($urandom_range(1, 4096));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8) send_noise();
         send_request(header_req(METHOD_STORED, fsize, (k > 0) ? 1'b1 : 1'($urandom),
                                 k < n - 1, rand64(), pick_length()));
         if ($urandom_range(0, 99) < 25) send_request(translate_req(pick_position()));
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response('{rsp_status, rsp_replaced, rsp_physical_offset,
                                  rsp_piece_index, rsp_bytes_left, rsp_clamped_position,
                                  rsp_total_size, rsp_piece_count});
   end

   initial begin
      #10_000_000;
      $display("tb_segmented_stream_chunk_map NOT OK");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned file_no;
      bit          hold_done;
      bit          drain_done;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_HEADER;
      req_method = '0;
      req_file_size = '0;
      req_has_previous = 1'b0;
      req_has_next = 1'b0;
      req_data_offset = '0;
      req_chunk_size = '0;
      req_position = '0;
      file_no = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lookups on an empty table and ignored compressed headers
      send_request(translate_req(64'd0));
      send_request(translate_req('1));
      send_request(header_req(8'h00, '1, 1'b1, 1'b1, '1, '1));
      send_request(header_req(8'hFF, '0, 1'b0, 1'b0, '0, '0));
      // first piece at the top of both ranges, a piece without continuation, an empty piece
      send_request(header_req(METHOD_STORED, '0, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, '1));
      send_request(header_req(METHOD_STORED, '0, 1'b0, 1'b1, 64'h10, 32'd7));
      send_request(header_req(METHOD_STORED, '0, 1'b1, 1'b1, '0, '0));
      send_request(header_req(METHOD_STORED, '0, 1'b1, 1'b1, 64'h1000, 32'd100));
      // start, past an empty piece, far beyond the end, exact end, inside the first piece
      send_request(translate_req(64'd0));
      send_request(translate_req(64'hFFFF_FFFF));
      send_request(translate_req('1));
      send_request(translate_req(64'h1_0000_0063));
      send_request(translate_req(64'hFFFF_FFFE));
      // larger file replaces, smaller file ignored then completes, header after completion
      send_request(header_req(METHOD_STORED, 64'd1, 1'b0, 1'b1, 64'd5000, 32'd10));
      send_request(header_req(METHOD_STORED, 64'd0, 1'b1, 1'b1, 64'd6000, 32'd3));
      send_request(header_req(METHOD_STORED, 64'd0, 1'b1, 1'b0, 64'd7000, 32'd3));
      send_request(header_req(METHOD_STORED, 64'd1, 1'b1, 1'b1, 64'd8000, 32'd4));
      send_request(header_req(8'h31, 64'd2, 1'b0, 1'b1, 64'd9000, 32'd4));
      send_request(translate_req(64'd9));
      send_request(translate_req(64'd10));
      send_request(header_req(METHOD_STORED, 64'd2, 1'b1, 1'b0, 64'hABCD, 32'd20));
      send_request(header_req(METHOD_STORED, 64'd2, 1'b1, 1'b1, 64'h1234, 32'd20));
      send_request(translate_req(64'd25));

      // random files, mostly well formed, some long enough to fill the table
      stim_count = 0;
      while (stim_count < RANDOM_ITEMS) begin
         if (!hold_done && stim_count >= 300) begin
            hold_done = 1'b1;
            rsp_hold_req = 1'b1;
         end
         if (!drain_done && stim_count >= 600) begin
            drain_done = 1'b1;
            wait_for_drain();
         end
         no_idle = (stim_count >= 900 && stim_count < 1150);
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            send_file((file_no % 8 == 1) ? $urandom_range(62, 70) : $urandom_range(1, 8));
            repeat ($urandom_range(1, 5)) send_request(translate_req(pick_position()));
            file_no++;
         end
      end
      no_idle = 1'b0;

      // largest declared size last, since nothing can replace it
      send_request(header_req(METHOD_STORED, '1, 1'b0, 1'b0, rand64(), pick_length()));
      send_request(translate_req(pick_position()));

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_results.size() == 0)
         $display("tb_segmented_stream_chunk_map OK");
      else
         $display("tb_segmented_stream_chunk_map NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sscm_pkg.sv
rtl/sscm_ram.sv
rtl/segmented_stream_chunk_map.sv
tb/tb_segmented_stream_chunk_map.sv
